// File: hw/rtl/tfr_pkg.sv
// shared types and constants of the two-axis frame rotation unit
`default_nettype none
package tfr_pkg;

	// default widths
	localparam int VECTOR_WIDTH_DEF = 24;
	localparam int AXIS_WIDTH_DEF   = 16;
	localparam int FRAC_BITS_DEF    = 16;

	// frame builder arithmetic
	localparam int UNIT_SHIFT      = 30;
	localparam int COLLINEAR_LIMIT = 256;

	// configuration register map
	localparam int CFG_INDEX_W = 3;
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FIRST_X    = 3'd0,
		REG_FIRST_Y    = 3'd1,
		REG_FIRST_Z    = 3'd2,
		REG_SECOND_X   = 3'd3,
		REG_SECOND_Y   = 3'd4,
		REG_SECOND_Z   = 3'd5,
		REG_AXIS_ORDER = 3'd6
	} tfr_reg_t;

	// row order of the matrix
	localparam logic [1:0] ORDER_ABC = 2'd0;
	localparam logic [1:0] ORDER_CAB = 2'd1;
	localparam logic [1:0] ORDER_BCA = 2'd2;

	// request operation
	typedef enum logic {
		OP_TO_GLOBAL = 1'b0,
		OP_TO_LOCAL  = 1'b1
	} tfr_op_t;

	// classification carried with each queued request
	typedef struct packed {
		tfr_op_t op;
		logic    err;
	} tfr_ctl_t;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

endpackage
`default_nettype wire

// File: hw/rtl/two_axis_frame_rotation_unit.sv
// top level of the two-axis frame rotation unit
`default_nettype none
// Rotates signed fixed-point 3-vectors by an orthonormal frame built from two
// configured axes. The frame builder normalizes the first axis (a), removes
// its part from the second axis and normalizes the rest (b), takes c = a x b,
// and stores the rows in the order axis_order picks (0: a,b,c  1: c,a,b
// 2: b,c,a) as signed Q1.FRAC_BITS entries. Reset loads the identity frame
// at once. Every register write starts a rebuild on one shared multiplier,
// a one-bit-per-cycle square root and a one-bit-per-cycle divider; most of it is
// spent in the two square roots and six divisions, and in_ready stays low until
// it is done. Back-to-back writes simply restart it. Once the frame is built,
// requests stream at one per cycle while out_ready is high: the front
// classifies each request into a two-entry queue and the back runs a
// two-stage multiply, round and saturate pipeline, from the queue head to the
// product register and then the output register. operation 0 multiplies
// by the transpose, 1 by the matrix. Collinear or zero axes, or an undefined
// axis_order, give zero outputs with basis_error set.
module two_axis_frame_rotation_unit import tfr_pkg::*; #(
	parameter int VECTOR_WIDTH = VECTOR_WIDTH_DEF,
	parameter int AXIS_WIDTH   = AXIS_WIDTH_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write port
	input  wire logic                    cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [AXIS_WIDTH-1:0]   cfg_data,
	// request channel
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    operation,
	input  wire logic [VECTOR_WIDTH-1:0] vec_x,
	input  wire logic [VECTOR_WIDTH-1:0] vec_y,
	input  wire logic [VECTOR_WIDTH-1:0] vec_z,
	// result channel
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic      [VECTOR_WIDTH-1:0] out_x,
	output logic      [VECTOR_WIDTH-1:0] out_y,
	output logic      [VECTOR_WIDTH-1:0] out_z,
	output logic                         basis_error
);

	// stored frame and builder status
	logic [8:0][FRAC_BITS+1:0]    matrix;
	logic                         frame_invalid;
	logic                         build_busy;

	// queue head toward the back end
	logic                         q_valid;
	tfr_ctl_t                     q_ctl;
	logic [2:0][VECTOR_WIDTH-1:0] q_vec;
	logic                         pop;

	tfr_builder #(
		.AXIS_WIDTH (AXIS_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_builder (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.matrix        (matrix),
		.frame_invalid (frame_invalid),
		.busy          (build_busy)
	);

	tfr_front #(
		.VECTOR_WIDTH (VECTOR_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.vec_x         (vec_x),
		.vec_y         (vec_y),
		.vec_z         (vec_z),
		.frame_invalid (frame_invalid),
		.build_busy    (build_busy),
		.pop           (pop),
		.q_valid       (q_valid),
		.q_ctl         (q_ctl),
		.q_vec         (q_vec)
	);

	tfr_back #(
		.VECTOR_WIDTH (VECTOR_WIDTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ctl       (q_ctl),
		.q_vec       (q_vec),
		.matrix      (matrix),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.basis_error (basis_error)
	);

`ifndef SYNTHESIS
	// no request may enter while the frame is being rebuilt
	a_no_accept_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		build_busy |-> !in_ready)
		else $error("request accepted during frame build");

	// an error result carries zero components
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && basis_error) |-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("error result with nonzero components");

	// a register write always starts a rebuild
	a_write_builds: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && cfg_index <= REG_AXIS_ORDER) |=> build_busy)
		else $error("register write did not start a frame build");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/tfr_builder.sv
// frame builder: config registers and the sequencer that derives the matrix
`default_nettype none
module tfr_builder import tfr_pkg::*; #(
	parameter int AXIS_WIDTH = AXIS_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]            cfg_index,
	input  wire logic [AXIS_WIDTH-1:0]             cfg_data,
	output logic      [8:0][FRAC_BITS+1:0]         matrix,
	output logic                                   frame_invalid,
	output logic                                   busy
);

	localparam int WW = 36;
	localparam int UW = 32;
	localparam int EW = FRAC_BITS + 2;
	localparam int ES = UNIT_SHIFT - FRAC_BITS;
	localparam logic signed [2*WW-1:0] RHALF = (2*WW)'(1) <<< (UNIT_SHIFT - 1);
	localparam logic signed [UW:0]     EHALF = ((UW + 1)'(1) <<< ES) >>> 1;
	localparam logic [WW-1:0]          MAG_LOW  = WW'(1) << UNIT_SHIFT;
	localparam logic [WW-1:0]          MAG_HIGH = WW'(1) << (UNIT_SHIFT + 1);
	localparam logic [EW-1:0]          MAT_ONE  = EW'(1) << FRAC_BITS;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_LOAD  = 12'b0000_0000_0010,
		S_PRE   = 12'b0000_0000_0100,
		S_SQ    = 12'b0000_0000_1000,
		S_SQRT  = 12'b0000_0001_0000,
		S_DIV   = 12'b0000_0010_0000,
		S_DOT   = 12'b0000_0100_0000,
		S_PROJ  = 12'b0000_1000_0000,
		S_COLL  = 12'b0001_0000_0000,
		S_CROSS = 12'b0010_0000_0000,
		S_DONE  = 12'b0100_0000_0000,
		S_FAIL  = 12'b1000_0000_0000
	} bld_state_t;

	typedef enum logic [2:0] {
		PH_A  = 3'b001,
		PH_BX = 3'b010,
		PH_B  = 3'b100
	} bld_phase_t;

	logic signed [AXIS_WIDTH-1:0] first_q [3];
	logic signed [AXIS_WIDTH-1:0] second_q [3];
	logic [1:0]                   order_q;

	bld_state_t state_q;
	bld_phase_t phase_q;
	logic [1:0] idx_q;
	logic [1:0] ph_q;
	logic [4:0] cnt_q;

	logic signed [WW-1:0]   v_q [3];
	logic signed [WW-1:0]   bx_q [3];
	logic signed [WW-1:0]   d_q;
	logic signed [UW-1:0]   ua_q [3];
	logic signed [UW-1:0]   ub_q [3];
	logic signed [UW-1:0]   uc_q [3];
	logic signed [2*WW-1:0] p_q;
	logic signed [2*WW-1:0] acc_q;
	logic [63:0]            sx_q;
	logic [63:0]            res_q;
	logic [63:0]            bit_q;
	logic [63:0]            rem_q;
	logic [63:0]            dsr_q;
	logic [UW-1:0]          quo_q;
	logic [8:0][EW-1:0]     matrix_q;
	logic                   invalid_q;

	logic [WW-1:0]          vmag [3];
	logic [WW-1:0]          vmax;
	logic signed [WW-1:0]   mul_a;
	logic signed [WW-1:0]   mul_b;
	logic signed [2*WW-1:0] acc_sum;
	logic [63:0]            sq_t;
	logic                   div_ge;
	logic [UW-1:0]          quo_nxt;
	logic signed [UW-1:0]   unit_nxt;
	logic [1:0]             jdx;
	logic [1:0]             kdx;
	logic signed [UW-1:0]   row0 [3];
	logic signed [UW-1:0]   row1 [3];
	logic signed [UW-1:0]   row2 [3];

	function automatic logic [1:0] nxt(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	function automatic logic signed [WW-1:0] rnd30(input logic signed [2*WW-1:0] x);
		logic signed [2*WW-1:0] t;
		t = (x + RHALF) >>> UNIT_SHIFT;
		return t[WW-1:0];
	endfunction

	function automatic logic [EW-1:0] rnd_entry(input logic signed [UW-1:0] x);
		logic signed [UW:0] t;
		t = ((UW + 1)'(x) + EHALF) >>> ES;
		return t[EW-1:0];
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q[0]  <= '0;
			first_q[1]  <= '0;
			first_q[2]  <= AXIS_WIDTH'(1);
			second_q[0] <= AXIS_WIDTH'(1);
			second_q[1] <= '0;
			second_q[2] <= '0;
			order_q     <= ORDER_BCA;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FIRST_X:    first_q[0]  <= cfg_data;
				REG_FIRST_Y:    first_q[1]  <= cfg_data;
				REG_FIRST_Z:    first_q[2]  <= cfg_data;
				REG_SECOND_X:   second_q[0] <= cfg_data;
				REG_SECOND_Y:   second_q[1] <= cfg_data;
				REG_SECOND_Z:   second_q[2] <= cfg_data;
				REG_AXIS_ORDER: order_q     <= cfg_data[1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vmag[i] = v_q[i][WW-1] ? WW'(-v_q[i]) : WW'(v_q[i]);
		end
		vmax = vmag[0];
		if (vmag[1] > vmax) vmax = vmag[1];
		if (vmag[2] > vmax) vmax = vmag[2];
	end

	assign jdx     = nxt(idx_q);
	assign kdx     = nxt(jdx);
	assign acc_sum = acc_q + p_q;
	assign sq_t    = res_q + bit_q;
	assign div_ge  = (rem_q >= dsr_q);
	assign quo_nxt = {quo_q[UW-2:0], div_ge};
	assign unit_nxt = v_q[idx_q][WW-1] ? -$signed(quo_nxt) : $signed(quo_nxt);

	// operands of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ: begin
				mul_a = v_q[idx_q];
				mul_b = v_q[idx_q];
			end
			S_DOT: begin
				mul_a = bx_q[idx_q];
				mul_b = WW'(ua_q[idx_q]);
			end
			S_PROJ: begin
				mul_a = d_q;
				mul_b = WW'(ua_q[idx_q]);
			end
			S_CROSS: begin
				if (ph_q == 2'd0) begin
					mul_a = WW'(ua_q[jdx]);
					mul_b = WW'(ub_q[kdx]);
				end else begin
					mul_a = WW'(ua_q[kdx]);
					mul_b = WW'(ub_q[jdx]);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	always_comb begin
		case (order_q)
			ORDER_ABC: begin
				row0 = ua_q; row1 = ub_q; row2 = uc_q;
			end
			ORDER_CAB: begin
				row0 = uc_q; row1 = ua_q; row2 = ub_q;
			end
			default: begin
				row0 = ub_q; row1 = uc_q; row2 = ua_q;
			end
		endcase
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					v_q[i]  <= WW'(first_q[i]);
					bx_q[i] <= WW'(second_q[i]);
				end
			end
			S_PRE: begin
				if (vmax != '0 && vmax < MAG_LOW) begin
					for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] <<< 1;
				end else if (vmax > MAG_HIGH) begin
					for (int i = 0; i < 3; i++) v_q[i] <= (v_q[i] + WW'(1)) >>> 1;
				end else if (phase_q == PH_BX) begin
					bx_q <= v_q;
				end
				acc_q <= '0;
			end
			S_SQ: begin
				if (ph_q != 2'd0) begin
					acc_q <= acc_sum;
					sx_q  <= acc_sum[63:0];
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			S_SQRT: begin
				if (sx_q >= sq_t) begin
					sx_q  <= sx_q - sq_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIV: begin
				if (ph_q == 2'd0) begin
					rem_q <= (64'(vmag[idx_q]) << UNIT_SHIFT) + 64'(res_q[UW-1:1]);
					dsr_q <= 64'(res_q[UW-1:0]) << (UW - 1);
				end else begin
					if (div_ge) rem_q <= rem_q - dsr_q;
					dsr_q <= dsr_q >> 1;
					quo_q <= quo_nxt;
					if (cnt_q == '0) begin
						if (phase_q == PH_A) ua_q[idx_q] <= unit_nxt;
						else ub_q[idx_q] <= unit_nxt;
						if (idx_q == 2'd2 && phase_q == PH_A) v_q <= bx_q;
					end
				end
			end
			S_DOT: begin
				if (ph_q != 2'd0) begin
					acc_q <= acc_sum;
					d_q   <= rnd30(acc_sum);
				end
			end
			S_PROJ: begin
				if (ph_q != 2'd0) v_q[idx_q] <= bx_q[idx_q] - rnd30(p_q);
			end
			S_CROSS: begin
				if (ph_q == 2'd1) acc_q <= p_q;
				if (ph_q == 2'd2) uc_q[idx_q] <= UW'(rnd30(acc_q - p_q));
			end
			default: ;
		endcase
	end

	// sequencer control and the stored matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_A;
			idx_q     <= '0;
			ph_q      <= '0;
			cnt_q     <= '0;
			invalid_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				matrix_q[i] <= (i == 0 || i == 4 || i == 8) ? MAT_ONE : '0;
			end
		end else begin
			case (state_q)
				S_IDLE: ;
				S_LOAD: begin
					phase_q <= PH_A;
					if (order_q inside {ORDER_ABC, ORDER_CAB, ORDER_BCA}) state_q <= S_PRE;
					else state_q <= S_FAIL;
				end
				S_PRE: begin
					idx_q <= '0;
					ph_q  <= '0;
					if (vmax == '0) begin
						state_q <= S_FAIL;
					end else if (vmax >= MAG_LOW && vmax <= MAG_HIGH) begin
						state_q <= (phase_q == PH_BX) ? S_DOT : S_SQ;
					end
				end
				S_SQ: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= '0;
						if (idx_q == 2'd2) begin
							cnt_q   <= 5'd31;
							state_q <= S_SQRT;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						idx_q   <= '0;
						ph_q    <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (ph_q == 2'd0) begin
						cnt_q <= 5'd31;
						ph_q  <= 2'd1;
					end else begin
						cnt_q <= cnt_q - 5'd1;
						if (cnt_q == '0) begin
							ph_q <= '0;
							if (idx_q == 2'd2) begin
								idx_q <= '0;
								if (phase_q == PH_A) begin
									phase_q <= PH_BX;
									state_q <= S_PRE;
								end else begin
									state_q <= S_CROSS;
								end
							end else begin
								idx_q <= idx_q + 2'd1;
							end
						end
					end
				end
				S_DOT, S_PROJ: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= '0;
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= (state_q == S_DOT) ? S_PROJ : S_COLL;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				S_COLL: begin
					phase_q <= PH_B;
					if (vmax < WW'(COLLINEAR_LIMIT)) state_q <= S_FAIL;
					else state_q <= S_PRE;
				end
				S_CROSS: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (idx_q == 2'd2) state_q <= S_DONE;
						else idx_q <= idx_q + 2'd1;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				S_DONE: begin
					for (int k = 0; k < 3; k++) begin
						matrix_q[k]     <= rnd_entry(row0[k]);
						matrix_q[3 + k] <= rnd_entry(row1[k]);
						matrix_q[6 + k] <= rnd_entry(row2[k]);
					end
					invalid_q <= 1'b0;
					state_q   <= S_IDLE;
				end
				S_FAIL: begin
					matrix_q  <= '0;
					invalid_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// any register write restarts the build
			if (cfg_write && cfg_index <= REG_AXIS_ORDER) state_q <= S_LOAD;
		end
	end

	assign matrix        = matrix_q;
	assign frame_invalid = invalid_q;
	assign busy          = (state_q != S_IDLE);

endmodule
`default_nettype wire

// File: hw/rtl/tfr_front.sv
// front end: request acceptance, classification and the request queue
`default_nettype none
module tfr_front import tfr_pkg::*; #(
	parameter int VECTOR_WIDTH = VECTOR_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          operation,
	input  wire logic [VECTOR_WIDTH-1:0]       vec_x,
	input  wire logic [VECTOR_WIDTH-1:0]       vec_y,
	input  wire logic [VECTOR_WIDTH-1:0]       vec_z,
	input  wire logic                          frame_invalid,
	input  wire logic                          build_busy,
	input  wire logic                          pop,
	output logic                               q_valid,
	output tfr_ctl_t                           q_ctl,
	output logic      [2:0][VECTOR_WIDTH-1:0]  q_vec
);

	tfr_ctl_t                     ctl_mem [QUEUE_DEPTH];
	logic [2:0][VECTOR_WIDTH-1:0] vec_mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]       wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]       rd_ptr_q;
	logic [QUEUE_PTR_W:0]         count_q;
	logic                         push;
	tfr_ctl_t                     ctl_in;

	assign in_ready = !build_busy && (count_q < (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;

	// an invalid frame turns the request into an error result
	assign ctl_in.op  = tfr_op_t'(operation);
	assign ctl_in.err = frame_invalid;

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_mem[wr_ptr_q] <= ctl_in;
			vec_mem[wr_ptr_q] <= {vec_z, vec_y, vec_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_PTR_W + 1)'(1);
				default: ;
			endcase
		end
	end

	assign q_valid = (count_q != '0);
	assign q_ctl   = ctl_mem[rd_ptr_q];
	assign q_vec   = vec_mem[rd_ptr_q];

endmodule
`default_nettype wire

// File: hw/rtl/tfr_back.sv
// back end: matrix-vector product pipeline with rounding and saturation
`default_nettype none
module tfr_back import tfr_pkg::*; #(
	parameter int VECTOR_WIDTH = VECTOR_WIDTH_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_valid,
	input  wire tfr_ctl_t                          q_ctl,
	input  wire logic      [2:0][VECTOR_WIDTH-1:0] q_vec,
	input  wire logic      [8:0][FRAC_BITS+1:0]    matrix,
	output logic                                   pop,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic           [VECTOR_WIDTH-1:0]      out_x,
	output logic           [VECTOR_WIDTH-1:0]      out_y,
	output logic           [VECTOR_WIDTH-1:0]      out_z,
	output logic                                   basis_error
);

	localparam int VW = VECTOR_WIDTH;
	localparam int CW = FRAC_BITS + 2;
	localparam int PW = VW + CW;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] RHALF  = SW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] LIM_HI = (SW'(1) <<< (VW - 1)) - SW'(1);
	localparam logic signed [SW-1:0] LIM_LO = -LIM_HI - SW'(1);

	logic                 adv;
	logic signed [PW-1:0] prod_d [3][3];
	logic signed [PW-1:0] prod_s1 [3][3];
	logic                 valid_s1;
	logic                 err_s1;
	logic [VW-1:0]        res_d [3];
	logic [VW-1:0]        res_q [3];
	logic                 err_q;
	logic                 valid_q;

	// whole pipeline moves when the output register is free
	assign adv = !valid_q || out_ready;
	assign pop = adv && q_valid;

	always_comb begin
		logic signed [VW-1:0] vk;
		logic signed [CW-1:0] ck;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				vk = $signed(q_vec[k]);
				ck = (q_ctl.op == OP_TO_LOCAL) ? $signed(matrix[i * 3 + k])
				                               : $signed(matrix[k * 3 + i]);
				prod_d[i][k] = PW'(vk) * PW'(ck);
			end
		end
	end

	always_comb begin
		logic signed [SW-1:0] sum;
		logic signed [SW-1:0] rnd;
		for (int i = 0; i < 3; i++) begin
			sum = SW'(prod_s1[i][0]) + SW'(prod_s1[i][1]) + SW'(prod_s1[i][2]);
			rnd = (sum + RHALF) >>> FRAC_BITS;
			if (err_s1) res_d[i] = '0;
			else if (rnd > LIM_HI) res_d[i] = LIM_HI[VW-1:0];
			else if (rnd < LIM_LO) res_d[i] = LIM_LO[VW-1:0];
			else res_d[i] = rnd[VW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1 <= prod_d;
			err_s1  <= q_ctl.err;
		end
		if (adv && valid_s1) begin
			res_q <= res_d;
			err_q <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
			valid_q  <= valid_s1;
		end
	end

	assign out_valid   = valid_q;
	assign out_x       = res_q[0];
	assign out_y       = res_q[1];
	assign out_z       = res_q[2];
	assign basis_error = err_q;

endmodule
`default_nettype wire
